/* rtl/gmsc_pkg.sv */
// Shared types, codes and constants for the graph mark-sweep collector.
`default_nettype none
package gmsc_pkg;

  // Default node count and the fixed width of node fields on the ports
  localparam int NODES_DEF = 16;
  localparam int NODE_W    = 4;

  // Command codes
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_MARK   = 2'd2,
    FN_REFCNT = 2'd3
  } func_t;

  // Reference matrix entry codes
  localparam logic [1:0] E_NONE = 2'b00;
  localparam logic [1:0] E_FWD  = 2'b01;
  localparam logic [1:0] E_REV  = 2'b11;

  // Input word
  typedef struct packed {
    func_t             func;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } gmsc_cmd_t;

  // Output word
  typedef struct packed {
    logic [NODE_W-1:0] deleted_node;
    logic              is_deletion;
    logic              last;
  } gmsc_del_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;           // latch the input word
    logic clr_step;       // clear one matrix entry after reset
    logic edge_fwd;       // write the forward entry of an edge
    logic edge_rev;       // write the reverse entry of an edge
    logic pass_init;      // start a collection pass
    logic fetch;          // read the mark queue at head
    logic load_cur;       // take the queue entry as the row to scan
    logic scan;           // issue/evaluate one matrix read of a row or column scan
    logic next_head;      // pop the mark queue
    logic emit;           // report the current node as deleted
    logic clr_node_step;  // clear one entry of the current node's row/column
    logic next_node;      // advance to the next node
    logic finish;         // send the final word of the pass
  } gmsc_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic is_pass;
    logic is_mark;
    logic edge_ok;
    logic list_nonempty;
    logic scan_done;
    logic held;
    logic node_marked;
    logic node_last;
    logic clr_node_done;
    logic out_free;
    logic have_pend;
  } gmsc_stat_t;

endpackage
`default_nettype wire

/* rtl/gmsc_ram.sv */
// Simple one-write, one-read memory with registered read data.
`default_nettype none
module gmsc_ram #(
  parameter int W  = 2,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/gmsc_ctrl.sv */
// Sequencing state machine for the graph mark-sweep collector.
`default_nettype none
module gmsc_ctrl import gmsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire gmsc_stat_t stat,
  output gmsc_ctl_t       ctl
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISPATCH,
    S_EDGE_A,
    S_EDGE_B,
    S_PASS_INIT,
    S_FETCH,
    S_LOAD,
    S_ROW_SCAN,
    S_NODE_TEST,
    S_COL_SCAN,
    S_EMIT,
    S_CLR_NODE,
    S_NEXT,
    S_FINISH
  } state_t;

  state_t state, state_next;

  // state register; reset starts the matrix clear
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = (state != S_IDLE);
    unique case (state)
      S_CLR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.take   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_pass) state_next = S_PASS_INIT;
        else if (stat.edge_ok) state_next = S_EDGE_A;
        else state_next = S_IDLE;
      end
      S_EDGE_A: begin
        ctl.edge_fwd = 1'b1;
        state_next   = S_EDGE_B;
      end
      S_EDGE_B: begin
        ctl.edge_rev = 1'b1;
        state_next   = S_IDLE;
      end
      S_PASS_INIT: begin
        ctl.pass_init = 1'b1;
        state_next    = stat.is_mark ? S_FETCH : S_COL_SCAN;
      end
      S_FETCH: begin
        if (stat.list_nonempty) begin
          ctl.fetch  = 1'b1;
          state_next = S_LOAD;
        end else begin
          state_next = S_NODE_TEST;
        end
      end
      S_LOAD: begin
        ctl.load_cur = 1'b1;
        state_next   = S_ROW_SCAN;
      end
      S_ROW_SCAN: begin
        if (stat.scan_done) begin
          ctl.next_head = 1'b1;
          state_next    = S_FETCH;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      S_NODE_TEST: begin
        state_next = stat.node_marked ? S_NEXT : S_EMIT;
      end
      S_COL_SCAN: begin
        if (stat.scan_done) begin
          state_next = stat.held ? S_NEXT : S_EMIT;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      S_EMIT: begin
        if (!stat.have_pend || stat.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_CLR_NODE;
        end
      end
      S_CLR_NODE: begin
        ctl.clr_node_step = 1'b1;
        if (stat.clr_node_done) state_next = S_NEXT;
      end
      S_NEXT: begin
        if (stat.node_last) begin
          state_next = S_FINISH;
        end else begin
          ctl.next_node = 1'b1;
          state_next    = stat.is_mark ? S_NODE_TEST : S_COL_SCAN;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/gmsc_dp.sv */
// Datapath: reference matrix, mark queue, flags, counters and output register.
`default_nettype none
module gmsc_dp import gmsc_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire gmsc_cmd_t  cmd,
  input  wire gmsc_ctl_t  ctl,
  output gmsc_stat_t      stat,
  output logic            del_valid,
  input  wire logic       del_stall,
  output gmsc_del_t       del
);

  localparam int NW  = $clog2(NODES);
  localparam int NWP = NW + 1;
  localparam int AW  = 2 * NW;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [NW:0]   NODES_CNT = NWP'(NODES);

  gmsc_cmd_t       req;
  gmsc_del_t       del_q;
  gmsc_del_t       word;
  logic [AW-1:0]   clr_cnt;
  logic [NW-1:0]   cur, node, kcnt, rd_idx, pend_node;
  logic [NW-1:0]   from_n, to_n, iss_idx;
  logic            kphase, rd_pend, held, have_pend;
  logic [NW:0]     iss_cnt, head, tail;
  logic [NODES-1:0] flags;
  logic            is_mark, fwd_hit, mark_hit, tail_room, push;

  logic            m_we, m_re;
  logic [AW-1:0]   m_waddr, m_raddr;
  logic [1:0]      m_wdata, m_rdata;
  logic            l_we;
  logic [NW-1:0]   l_waddr, l_wdata, l_rdata;

  assign from_n    = NW'(req.from_node);
  assign to_n      = NW'(req.to_node);
  assign is_mark   = (req.func == FN_MARK);
  assign iss_idx   = iss_cnt[NW-1:0];
  assign fwd_hit   = rd_pend && (m_rdata == E_FWD);
  assign mark_hit  = ctl.scan && is_mark && fwd_hit && !flags[rd_idx];
  assign tail_room = (tail < NODES_CNT);

  // matrix write port select
  always_comb begin
    m_we    = 1'b0;
    m_waddr = clr_cnt;
    m_wdata = E_NONE;
    if (ctl.clr_step) begin
      m_we = 1'b1;
    end else if (ctl.edge_fwd) begin
      m_we    = 1'b1;
      m_waddr = {from_n, to_n};
      m_wdata = (req.func == FN_INSERT) ? E_FWD : E_NONE;
    end else if (ctl.edge_rev) begin
      m_we    = 1'b1;
      m_waddr = {to_n, from_n};
      m_wdata = (req.func == FN_INSERT) ? E_REV : E_NONE;
    end else if (ctl.clr_node_step) begin
      m_we    = 1'b1;
      m_waddr = kphase ? {kcnt, node} : {node, kcnt};
    end
  end

  // matrix read: a row of the current node when marking, a column when counting
  assign m_re    = ctl.scan && (iss_cnt != NODES_CNT);
  assign m_raddr = is_mark ? {cur, iss_idx} : {iss_idx, node};

  gmsc_ram #(.W(2), .AW(AW)) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // breadth-first mark queue
  assign l_we    = ctl.pass_init || (mark_hit && tail_room);
  assign l_waddr = ctl.pass_init ? '0 : tail[NW-1:0];
  assign l_wdata = ctl.pass_init ? '0 : rd_idx;

  gmsc_ram #(.W(NW), .AW(NW)) u_mark_list (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (ctl.fetch),
    .raddr (head[NW-1:0]),
    .rdata (l_rdata)
  );

  // output word: held deletion, closed by the final word of the pass
  assign push = (ctl.emit && have_pend) || ctl.finish;
  always_comb begin
    if (ctl.finish && !have_pend) begin
      word.deleted_node = '0;
      word.is_deletion  = 1'b0;
      word.last         = 1'b1;
    end else begin
      word.deleted_node = NODE_W'(pend_node);
      word.is_deletion  = 1'b1;
      word.last         = ctl.finish;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      iss_cnt   <= '0;
      rd_pend   <= 1'b0;
      held      <= 1'b0;
      head      <= '0;
      tail      <= '0;
      flags     <= '0;
      node      <= '0;
      kcnt      <= '0;
      kphase    <= 1'b0;
      have_pend <= 1'b0;
      del_valid <= 1'b0;
    end else begin
      if (ctl.clr_step) clr_cnt <= clr_cnt + 1'b1;

      // scan read pipeline
      if (ctl.pass_init || ctl.load_cur || ctl.next_node) begin
        iss_cnt <= '0;
        rd_pend <= 1'b0;
        held    <= 1'b0;
      end else if (ctl.scan) begin
        rd_pend <= m_re;
        if (m_re) iss_cnt <= iss_cnt + 1'b1;
        if (fwd_hit) held <= 1'b1;
      end

      // mark flags and queue pointers; only the root starts marked
      if (ctl.pass_init) begin
        flags <= NODES'(1);
        head  <= '0;
        tail  <= NWP'(1);
      end else begin
        if (mark_hit) flags[rd_idx] <= 1'b1;
        if (ctl.next_head) head <= head + 1'b1;
        if (mark_hit && tail_room) tail <= tail + 1'b1;
      end

      // node walk
      if (ctl.pass_init) node <= NW'(1);
      else if (ctl.next_node) node <= node + 1'b1;

      // row/column clear of a deleted node
      if (ctl.emit) begin
        kcnt   <= '0;
        kphase <= 1'b0;
      end else if (ctl.clr_node_step) begin
        kphase <= !kphase;
        if (kphase) kcnt <= kcnt + 1'b1;
      end

      if (ctl.pass_init) have_pend <= 1'b0;
      else if (ctl.emit) have_pend <= 1'b1;

      // output register
      if (push) del_valid <= 1'b1;
      else if (!del_stall) del_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.take) req <= cmd;
    if (ctl.load_cur) cur <= l_rdata;
    if (m_re) rd_idx <= iss_idx;
    if (ctl.emit) pend_node <= node;
    if (push) del_q <= word;
  end

  assign del = del_q;

  // status
  always_comb begin
    stat.clr_done      = &clr_cnt;
    stat.is_pass       = (req.func == FN_MARK) || (req.func == FN_REFCNT);
    stat.is_mark       = is_mark;
    stat.edge_ok       = (int'(req.from_node) < NODES) && (int'(req.to_node) < NODES);
    stat.list_nonempty = (head < tail);
    stat.scan_done     = (iss_cnt == NODES_CNT) && !rd_pend;
    stat.held          = held;
    stat.node_marked   = flags[node];
    stat.node_last     = (node == LAST_NODE);
    stat.clr_node_done = kphase && (kcnt == LAST_NODE);
    stat.out_free      = !del_valid || !del_stall;
    stat.have_pend     = have_pend;
  end

  // a word is never loaded over one that is still stalled
  a_push_free: assert property (@(posedge clk) disable iff (rst) push |-> stat.out_free)
    else $error("output word overwritten while stalled");

  // queue pointers stay ordered and bounded
  a_queue: assert property (@(posedge clk) disable iff (rst)
    (head <= tail) && (tail <= NODES_CNT))
    else $error("mark queue pointers out of order");

  // the final word of a pass carries last
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> del_valid && del.last)
    else $error("pass ended without a last word");

  // the root stays marked while the queue is walked
  a_root_marked: assert property (@(posedge clk) disable iff (rst) ctl.fetch |-> flags[0])
    else $error("root node not marked during mark phase");

endmodule
`default_nettype wire

/* rtl/graph_mark_sweep_collector_unit.sv */
// Top level of the graph mark-sweep collector: controller plus datapath.
//
//   channel  | handshake            | word        | carries
//   ---------+----------------------+-------------+--------------------------------
//   command  | cmd_valid, cmd_stall | cmd         | func, from_node, to_node
//   deletion | del_valid, del_stall | del         | deleted_node, is_deletion, last
//
// After reset the block clears all 2**(2*clog2(NODES)) entries of the reference
// matrix (256 at 16 nodes), one entry a cycle, with cmd_stall high.
// After accepting an insert or remove it holds cmd_stall through the dispatch
// and both edge-write states, so it takes no new word before that one is done.
// The matrix has one read and one write port, one entry each per cycle, which
// sets the pass length: mark-and-sweep scans the row of each reached node and
// tests each swept node, and clears row and column of each deleted node; a
// reference-count pass scans each node's column, then clears each deleted one.
// A stalled deletion word holds the pass at its next report until it is taken.
`default_nettype none
module graph_mark_sweep_collector_unit import gmsc_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire gmsc_cmd_t cmd,
  output logic           del_valid,
  input  wire logic      del_stall,
  output gmsc_del_t      del
);

  gmsc_ctl_t  ctl;
  gmsc_stat_t stat;

  gmsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  gmsc_dp #(.NODES(NODES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .del_valid (del_valid),
    .del_stall (del_stall),
    .del       (del)
  );

endmodule
`default_nettype wire

/* tb/sv/graph_mark_sweep_collector_unit_tb.sv */
// Self-checking testbench for the graph mark-sweep collector unit.
`timescale 1ns / 1ps
module graph_mark_sweep_collector_unit_tb import gmsc_pkg::*;;

  localparam int QUIET_LIMIT  = 20000;  // cycles with no word moving on either channel
  localparam int HOLD_CYCLES  = 1500;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 64;     // covers clearing the last deleted node

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  gmsc_cmd_t cmd = '0;
  logic      del_valid;
  logic      del_stall = 1'b0;
  gmsc_del_t del;

  // Shared control between stimulus and the receiver process
  bit gap_on   = 1'b1;
  int hold_len = 0;
  int err_count = 0;

  // Model of the reference matrix and the deletion words still owed
  logic [1:0] ref_map [NODES_DEF][NODES_DEF];
  gmsc_del_t  expected_dels [$];

  graph_mark_sweep_collector_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .del_valid(del_valid),
    .del_stall(del_stall),
    .del      (del)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void drop_node(input int n);
    for (int k = 0; k < NODES_DEF; k++) begin
      ref_map[n][k] = E_NONE;
      ref_map[k][n] = E_NONE;
    end
  endfunction

  function automatic void log_deletion(input int n);
    gmsc_del_t w;
    w.deleted_node = n[NODE_W-1:0];
    w.is_deletion  = 1'b1;
    w.last         = 1'b0;
    expected_dels.push_back(w);
    drop_node(n);
  endfunction

  // Flag the final word of a pass, or owe an empty-pass marker
  function automatic void close_pass(input int found);
    gmsc_del_t w;
    if (found == 0) begin
      w = '0;
      w.last = 1'b1;
    end else begin
      w = expected_dels.pop_back();
      w.last = 1'b1;
    end
    expected_dels.push_back(w);
  endfunction

  function automatic void model_mark_sweep();
    bit reached [NODES_DEF];
    int frontier [$];
    int cur;
    int found;
    found = 0;
    foreach (reached[i]) reached[i] = 1'b0;
    reached[0] = 1'b1;
    frontier.push_back(0);
    // breadth-first over forward entries only
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      for (int n = 1; n < NODES_DEF; n++) begin
        if (ref_map[cur][n] == E_FWD && !reached[n]) begin
          reached[n] = 1'b1;
          frontier.push_back(n);
        end
      end
    end
    // sweep in ascending order; marks are already final
    for (int n = 1; n < NODES_DEF; n++) begin
      if (!reached[n]) begin
        log_deletion(n);
        found++;
      end
    end
    close_pass(found);
  endfunction

  function automatic void model_ref_count();
    bit held;
    int found;
    found = 0;
    // deletions clear columns, so later nodes see the cascade
    for (int n = 1; n < NODES_DEF; n++) begin
      held = 1'b0;
      for (int k = 0; k < NODES_DEF; k++)
        if (ref_map[k][n] == E_FWD) held = 1'b1;
      if (!held) begin
        log_deletion(n);
        found++;
      end
    end
    close_pass(found);
  endfunction

  function automatic void model_command(input gmsc_cmd_t c);
    case (c.func)
      FN_INSERT: begin
        ref_map[c.from_node][c.to_node] = E_FWD;
        ref_map[c.to_node][c.from_node] = E_REV;
      end
      FN_REMOVE: begin
        ref_map[c.from_node][c.to_node] = E_NONE;
        ref_map[c.to_node][c.from_node] = E_NONE;
      end
      FN_MARK:   model_mark_sweep();
      FN_REFCNT: model_ref_count();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic gmsc_cmd_t make_cmd(input func_t f, input int a, input int b);
    gmsc_cmd_t c;
    c.func      = f;
    c.from_node = a[NODE_W-1:0];
    c.to_node   = b[NODE_W-1:0];
    return c;
  endfunction

  // Offer one command word and hold it until taken; valid stays high on return
  task automatic send_word(input gmsc_cmd_t c);
    if (gap_on && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    model_command(c);
  endtask

  // Receiver: long hold-off on request, otherwise random stall bursts
  always begin
    @(posedge clk);
    if (hold_len > 0) begin
      del_stall <= 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_len = 0;
      del_stall <= 1'b0;
    end else if (gap_on && $urandom_range(0, 5) == 0) begin
      del_stall <= 1'b1;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      del_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    gmsc_del_t want;
    if (!rst && del_valid && !del_stall) begin
      if (expected_dels.size() == 0) begin
        $display("%0t: unexpected deletion word node=%0d del=%0b last=%0b",
                 $time, del.deleted_node, del.is_deletion, del.last);
        err_count++;
      end else begin
        want = expected_dels.pop_front();
        if (del.deleted_node != want.deleted_node || del.is_deletion != want.is_deletion ||
            del.last != want.last) begin
          $display("%0t: expected node=%0d del=%0b last=%0b, got node=%0d del=%0b last=%0b",
                   $time, want.deleted_node, want.is_deletion, want.last,
                   del.deleted_node, del.is_deletion, del.last);
          err_count++;
        end
      end
    end
  end

  // Watchdog on progress of either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (del_valid && !del_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // Chain 0->1->...->15 keeps every node reachable and referenced: both passes empty
  task automatic test_full_chain();
    for (int i = 0; i < NODES_DEF - 1; i++)
      send_word(make_cmd(FN_INSERT, i, i + 1));
    send_word(make_cmd(FN_MARK, 0, 0));
    send_word(make_cmd(FN_REFCNT, 0, 0));
  endtask

  // Self edges, extreme indices, a broken chain and repeated isolated nodes
  task automatic test_corner_edges();
    send_word(make_cmd(FN_INSERT, 5, 5));
    send_word(make_cmd(FN_REMOVE, 15, 15));
    send_word(make_cmd(FN_INSERT, 15, 0));
    send_word(make_cmd(FN_REMOVE, 0, 15));
    send_word(make_cmd(FN_REMOVE, 7, 8));
    send_word(make_cmd(FN_MARK, 15, 15));
    send_word(make_cmd(FN_REFCNT, 10, 5));
    send_word(make_cmd(FN_REFCNT, 0, 15));
  endtask

  // Receiver holds off while passes keep coming, so the block backs up
  task automatic test_result_backpressure();
    hold_len = HOLD_CYCLES;
    @(posedge clk);
    for (int i = 0; i < 6; i++)
      send_word(make_cmd((i % 2 == 0) ? FN_MARK : FN_REFCNT, i, 15 - i));
  endtask

  // Mostly edge walks from the root followed by a pass, with some noise
  task automatic run_random_traffic(input int count);
    int walk;
    int nxt;
    int pick;
    walk = 0;
    for (int sent = 0; sent < count; sent++) begin
      pick = $urandom_range(0, 19);
      nxt  = $urandom_range(0, NODES_DEF - 1);
      if (pick < 11) begin
        send_word(make_cmd(FN_INSERT, walk, nxt));
        walk = ($urandom_range(0, 2) == 0) ? 0 : nxt;
      end else if (pick < 14) begin
        send_word(make_cmd(FN_REMOVE, walk, nxt));
      end else if (pick < 16) begin
        send_word(make_cmd(func_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                           $urandom_range(0, 15)));
      end else begin
        send_word(make_cmd(($urandom_range(0, 1) == 1) ? FN_MARK : FN_REFCNT,
                           $urandom_range(0, 15), $urandom_range(0, 15)));
        walk = 0;
      end
    end
  endtask

  task automatic test_random_graphs();
    run_random_traffic(280);
  endtask

  // Closing stretch with both sides running flat out
  task automatic test_steady_stream();
    gap_on = 1'b0;
    run_random_traffic(60);
  endtask

  initial begin
    foreach (ref_map[i, j]) ref_map[i][j] = E_NONE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_full_chain();
    test_corner_edges();
    test_result_backpressure();
    test_random_graphs();
    test_steady_stream();
    cmd_valid <= 1'b0;
    while (expected_dels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
